// ----- rtl/hcld_pkg.sv -----
`default_nettype none
package hcld_pkg;

  // Longest line: MAX_LINE-1 characters before the newline.
  localparam int MAX_LINE = 64;
  localparam int POS_W    = 7;

  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

  typedef enum logic [2:0] {
    PAT_CONNECT    = 3'd0,
    PAT_START      = 3'd1,
    PAT_GOAL       = 3'd2,
    PAT_RIGHT      = 3'd3,
    PAT_LEFT       = 3'd4,
    PAT_LONG_RIGHT = 3'd5,
    PAT_LONG_LEFT  = 3'd6
  } pattern_t;

  // Request from the line parser to the segment sequencer.
  typedef struct packed {
    logic     valid;
    pattern_t code;
  } cmd_push_t;

endpackage
`default_nettype wire

// ----- rtl/hcld_in_if.sv -----
`default_nettype none
interface hcld_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface
`default_nettype wire

// ----- rtl/hcld_out_if.sv -----
`default_nettype none
interface hcld_out_if;
  logic        valid;
  logic        ready;
  logic        drive_high;
  logic        drive_low;
  logic [12:0] duration_ms;
  logic [2:0]  pattern_code;
  logic        last_segment;

  modport source (output valid, output drive_high, output drive_low, output duration_ms,
                  output pattern_code, output last_segment, input ready);
  modport sink (input valid, input drive_high, input drive_low, input duration_ms,
                input pattern_code, input last_segment, output ready);
endinterface
`default_nettype wire

// ----- rtl/hcld_front.sv -----
`default_nettype none
module hcld_front (
  input  wire logic          clk,
  input  wire logic          rst,
  hcld_in_if.sink            rx,
  input  wire logic          q_full,
  output hcld_pkg::cmd_push_t push
);

  localparam int CONNECT_LEN = 6;
  localparam int HEADER_LEN  = 11;

  logic [hcld_pkg::POS_W-1:0] char_position;
  logic                       connect_prefix_ok;
  logic                       header_prefix_ok;
  logic [4:0]                 pending_high_nibble;
  logic [2:0]                 first_command;
  logic                       overflow_discard;
  logic [1:0]                 phase;

  logic       beat;
  logic [7:0] c;
  logic       dropped;
  logic       is_newline;
  logic [4:0] lo_nib;
  logic [7:0] pair_code;
  logic       in_pairs;
  logic       con_hit;
  logic       hdr_hit;

  function automatic logic [7:0] connect_char(input logic [2:0] idx);
    logic [7:0] r;
    unique case (idx)
      3'd0:    r = "C";
      3'd1:    r = "O";
      3'd2:    r = "N";
      3'd3:    r = "E";
      3'd4:    r = "C";
      default: r = "T";
    endcase
    return r;
  endfunction

  function automatic logic [7:0] header_char(input logic [3:0] idx);
    logic [7:0] r;
    unique case (idx)
      4'd2, 4'd7: r = ",";
      4'd10:      r = ":";
      default:    r = "0";
    endcase
    return r;
  endfunction

  // Bit 4 marks a valid uppercase hex digit, bits 3..0 hold its value.
  function automatic logic [4:0] hex_nibble(input logic [7:0] ch);
    logic [4:0] r;
    logic [7:0] d;
    r = 5'd0;
    if (ch >= "0" && ch <= "9") begin
      d = ch - 8'h30;
      r = {1'b1, d[3:0]};
    end else if (ch >= "A" && ch <= "F") begin
      d = ch - 8'h37;
      r = {1'b1, d[3:0]};
    end
    return r;
  endfunction

  function automatic logic [2:0] command_of(input logic [7:0] code);
    logic [2:0] r;
    unique case (code)
      8'h73:   r = hcld_pkg::PAT_START;
      8'h67:   r = hcld_pkg::PAT_GOAL;
      8'h72:   r = hcld_pkg::PAT_RIGHT;
      8'h6C:   r = hcld_pkg::PAT_LEFT;
      8'h52:   r = hcld_pkg::PAT_LONG_RIGHT;
      8'h4C:   r = hcld_pkg::PAT_LONG_LEFT;
      default: r = 3'd0;
    endcase
    return r;
  endfunction

  assign rx.ready   = !q_full;
  assign beat       = rx.valid && rx.ready;
  assign c          = rx.rx_byte;
  assign dropped    = (c == 8'h00) || c[7];
  assign is_newline = (c == hcld_pkg::CHAR_NEWLINE);
  assign lo_nib     = hex_nibble(c);
  assign pair_code  = {pending_high_nibble[3:0], lo_nib[3:0]};
  assign in_pairs   = (char_position >= hcld_pkg::POS_W'(HEADER_LEN));
  assign con_hit    = connect_prefix_ok && (char_position >= hcld_pkg::POS_W'(CONNECT_LEN));
  assign hdr_hit    = header_prefix_ok && in_pairs && (first_command != 3'd0);

  always_comb begin
    push.valid = beat && !dropped && is_newline && !overflow_discard && (con_hit || hdr_hit);
    push.code  = con_hit ? hcld_pkg::PAT_CONNECT : hcld_pkg::pattern_t'(first_command);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      char_position       <= '0;
      connect_prefix_ok   <= 1'b1;
      header_prefix_ok    <= 1'b1;
      pending_high_nibble <= '0;
      first_command       <= '0;
      overflow_discard    <= 1'b0;
      phase               <= '0;
    end else if (beat && !dropped) begin
      if (is_newline) begin
        char_position       <= '0;
        connect_prefix_ok   <= 1'b1;
        header_prefix_ok    <= 1'b1;
        pending_high_nibble <= '0;
        first_command       <= '0;
        overflow_discard    <= 1'b0;
        phase               <= '0;
      end else if (!overflow_discard) begin
        if (char_position >= hcld_pkg::POS_W'(hcld_pkg::MAX_LINE - 1)) begin
          overflow_discard <= 1'b1;
        end else begin
          if (char_position < hcld_pkg::POS_W'(CONNECT_LEN) &&
              c != connect_char(char_position[2:0]))
            connect_prefix_ok <= 1'b0;
          if (!in_pairs && c != header_char(char_position[3:0]))
            header_prefix_ok <= 1'b0;
          if (in_pairs) begin
            // Group of three: high digit, low digit, separator.
            if (phase == 2'd0) begin
              pending_high_nibble <= lo_nib;
            end else if (phase == 2'd1) begin
              if (first_command == 3'd0 && pending_high_nibble[4] && lo_nib[4])
                first_command <= command_of(pair_code);
            end
            phase <= (phase == 2'd2) ? 2'd0 : phase + 2'd1;
          end
          char_position <= char_position + 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/hcld_queue.sv -----
`default_nettype none
module hcld_queue (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire hcld_pkg::cmd_push_t push,
  output logic                    full,
  output logic                    not_empty,
  output hcld_pkg::pattern_t      head,
  input  wire logic               pop
);

  hcld_pkg::pattern_t entries [2];
  logic               wr_ptr;
  logic               rd_ptr;
  logic [1:0]         count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign head      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push.valid && !full) entries[wr_ptr] <= push.code;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push.valid && !full) wr_ptr <= !wr_ptr;
      if (pop && not_empty)    rd_ptr <= !rd_ptr;
      count <= count + {1'b0, push.valid && !full} - {1'b0, pop && not_empty};
    end
  end

endmodule
`default_nettype wire

// ----- rtl/hcld_back.sv -----
`default_nettype none
module hcld_back (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               q_not_empty,
  input  wire hcld_pkg::pattern_t q_head,
  output logic                    q_pop,
  hcld_out_if.source              seg
);

  typedef struct packed {
    logic        right;
    logic        left;
    logic [12:0] ms;
    logic        last;
  } segment_t;

  function automatic segment_t seg_of(input hcld_pkg::pattern_t code, input logic [2:0] idx);
    segment_t s;
    logic     on;
    on     = !idx[0];
    s      = '0;
    unique case (code)
      hcld_pkg::PAT_CONNECT: begin
        s.right = on;
        s.left  = on;
        s.ms    = idx[0] ? (idx[1] ? 13'd0 : 13'd75) : 13'd125;
        s.last  = (idx == 3'd3);
      end
      hcld_pkg::PAT_START: begin
        s.right = on;
        s.left  = on;
        s.ms    = (idx == 3'd7) ? 13'd0 :
                  (idx == 3'd1 || idx == 3'd5) ? 13'd100 : 13'd200;
        s.last  = (idx == 3'd7);
      end
      hcld_pkg::PAT_GOAL: begin
        s.right = on;
        s.left  = on;
        s.ms    = on ? 13'd5000 : 13'd100;
        s.last  = (idx == 3'd1);
      end
      hcld_pkg::PAT_RIGHT, hcld_pkg::PAT_LEFT: begin
        s.right = on && (code == hcld_pkg::PAT_RIGHT);
        s.left  = on && (code == hcld_pkg::PAT_LEFT);
        s.ms    = idx[0] ? (idx[1] ? 13'd0 : 13'd100) : 13'd450;
        s.last  = (idx == 3'd3);
      end
      hcld_pkg::PAT_LONG_RIGHT, hcld_pkg::PAT_LONG_LEFT: begin
        s.right = on && (code == hcld_pkg::PAT_LONG_RIGHT);
        s.left  = on && (code == hcld_pkg::PAT_LONG_LEFT);
        s.ms    = on ? 13'd1500 : 13'd100;
        s.last  = (idx == 3'd1);
      end
      default: s = '0;
    endcase
    return s;
  endfunction

  logic               busy;
  hcld_pkg::pattern_t code;
  logic [2:0]         idx;
  logic               out_valid;
  segment_t           out_seg;
  hcld_pkg::pattern_t out_code;

  logic               load;
  hcld_pkg::pattern_t src_code;
  logic [2:0]         src_idx;
  segment_t           nxt;

  // Output register takes a new segment whenever it is empty or being taken and a segment is pending.
  assign load     = (!out_valid || seg.ready) && (busy || q_not_empty);
  assign q_pop    = (!out_valid || seg.ready) && !busy && q_not_empty;
  assign src_code = busy ? code : q_head;
  assign src_idx  = busy ? idx : 3'd0;
  assign nxt      = seg_of(src_code, src_idx);

  assign seg.valid        = out_valid;
  assign seg.drive_high   = out_seg.right;
  assign seg.drive_low    = out_seg.left;
  assign seg.duration_ms  = out_seg.ms;
  assign seg.pattern_code = out_code;
  assign seg.last_segment = out_seg.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        busy      <= !nxt.last;
        idx       <= src_idx + 3'd1;
      end else if (seg.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      code     <= src_code;
      out_code <= src_code;
      out_seg  <= nxt;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/hex_command_line_decoder.sv -----
// Serial command-line decoder.
// rx: one received byte per beat. Bytes 0x00 and 0x80..0xFF are ignored;
// a newline (0x0A) closes the line and may start a pattern run.
// seg: one drive segment per beat (right/left levels, hold time in ms,
// pattern code, last-segment flag). A run is 2, 4 or 8 segments.
// The newline beat writes the run's command into the queue; the sequencer
// loads its first segment from the queue head into the output register, and
// further segments follow one per cycle while seg is ready.
// Throughput: one byte per cycle on rx. A two-entry command queue sits
// between the line parser and the segment sequencer, so bytes keep flowing
// while a run is played out; rx.ready drops only when that queue is full
// (two runs waiting behind the one in progress).
// A stalled seg receiver holds the current segment in the output register;
// the sequencer and then the queue fill behind it.
// Reset (rst, synchronous) clears the line state, empties the queue and
// drops any segment not yet taken.
`default_nettype none
module hex_command_line_decoder (
  input  wire logic  clk,
  input  wire logic  rst,
  hcld_in_if.sink    rx,
  hcld_out_if.source seg
);

  hcld_pkg::cmd_push_t push;
  logic                q_full;
  logic                q_not_empty;
  logic                q_pop;
  hcld_pkg::pattern_t  q_head;

  hcld_front u_front (
    .clk    (clk),
    .rst    (rst),
    .rx     (rx),
    .q_full (q_full),
    .push   (push)
  );

  hcld_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (q_head),
    .pop       (q_pop)
  );

  hcld_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .seg         (seg)
  );

endmodule
`default_nettype wire
